FILE: src/ffha_pkg.sv
// package: shared types and codes for the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADPTR  = 2'd2;
  localparam int HDR_BYTES = 8;
  typedef struct packed {
    logic       func;
    logic [15:0] request_size;
    logic [15:0] payload_offset;
  } in_word_t;
  typedef struct packed {
    logic [15:0] result_offset;
    logic [1:0]  status;
    logic [16:0] bytes_in_use;
    logic [13:0] blocks_in_use;
  } out_word_t;
endpackage

FILE: src/ffha_stream_if.sv
// interface: valid/ready stream channel carrying one word
`timescale 1ns / 1ps
interface ffha_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/first_fit_heap_allocator_top.sv
// top level: first-fit heap allocator with chunk headers in one synchronous memory
//
//  channel  dir  word
//  in_      in   func, request_size, payload_offset
//  out_     out  result_offset, status, bytes_in_use, blocks_in_use
//
// each request walks chunk headers one at a time through the single header memory port
// (S_RD reads a header, S_CHK uses the data); splits and merges add more reads/writes.
// rst_n synchronous active low; the first header is written from a reset flag.
// one request at a time; new input waits while a result sits in the output register.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  ffha_stream_if.sink   in_ch,
  ffha_stream_if.source out_ch
);
  localparam int DEPTH = HEAP_BYTES / 8;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [17:0] REGION_END = 18'(DEPTH * 8);
  localparam logic [16:0] INIT_SIZE = 17'(DEPTH * 8 - 8);

  typedef struct packed {
    logic        used;
    logic [16:0] size;
    logic [16:0] prev;
  } hdr_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_CHK   = 11'b00000000100,
    S_SPL   = 11'b00000001000,
    S_POST  = 11'b00000010000,
    S_RRD   = 11'b00000100000,
    S_RCHK  = 11'b00001000000,
    S_LCHK  = 11'b00010000000,
    S_NRD   = 11'b00100000000,
    S_NWR   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  hdr_t mem [DEPTH];
  hdr_t rd_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  hdr_t wdata;

  state_t state_r, state_nxt;
  logic init_r;
  ffha_pkg::in_word_t in_w;
  ffha_pkg::in_word_t req_r, req_nxt;
  logic [17:0] p_r, p_nxt;
  hdr_t h_r, h_nxt;
  logic [17:0] l_r, l_nxt;
  logic [16:0] sz_r, sz_nxt;
  logic [17:0] nx_r, nx_nxt;
  logic rf_r, rf_nxt;
  logic [16:0] bytes_r, bytes_nxt;
  logic [13:0] blocks_r, blocks_nxt;
  ffha_pkg::out_word_t ow_r, ow_nxt;
  logic ov_r, ov_nxt;

  logic [16:0] rq;
  logic [17:0] off18;
  assign in_w = ffha_pkg::in_word_t'(in_ch.data);
  assign rq = (17'(req_r.request_size) + 17'd7) & ~17'd7;
  assign off18 = 18'(req_r.payload_offset);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r <= 1'b1;
      bytes_r <= '0;
      blocks_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r <= 1'b0;
      bytes_r <= bytes_nxt;
      blocks_r <= blocks_nxt;
      ov_r <= ov_nxt;
    end
    req_r <= req_nxt; p_r <= p_nxt; h_r <= h_nxt;
    l_r <= l_nxt; sz_r <= sz_nxt; nx_r <= nx_nxt; rf_r <= rf_nxt; ow_r <= ow_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE) && !init_r && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = ow_r;

  always_comb begin
    state_nxt = state_r; req_nxt = req_r; p_nxt = p_r; h_nxt = h_r;
    l_nxt = l_r; sz_nxt = sz_r; nx_nxt = nx_r; rf_nxt = rf_r;
    bytes_nxt = bytes_r; blocks_nxt = blocks_r; ow_nxt = ow_r; ov_nxt = ov_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = AW'(p_r >> 3);
    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;
    if (init_r) begin
      we = 1'b1; wdata = '{used: 1'b0, size: INIT_SIZE, prev: 17'd0};
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          req_nxt = in_w;
          p_nxt = '0;
          if (in_w.func == ffha_pkg::FUNC_FREE &&
              (in_w.payload_offset < 16'd8 ||
               18'(in_w.payload_offset) >= REGION_END)) begin
            ow_nxt = '{16'd0, ffha_pkg::ST_BADPTR, bytes_r, blocks_r};
            state_nxt = S_OUT;
          end else state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        h_nxt = rd_q;
        p_nxt = p_r + 18'(ffha_pkg::HDR_BYTES) + 18'(rd_q.size);
        state_nxt = S_RD;
        if (req_r.func == ffha_pkg::FUNC_ALLOC) begin
          if (!rd_q.used && rd_q.size >= rq) begin
            p_nxt = p_r;
            we = 1'b1; waddr = AW'(p_r >> 3);
            bytes_nxt = bytes_r;
            if (18'(rd_q.size) >= 18'(rq) + 18'd16) begin
              wdata = '{1'b1, rq, rd_q.prev};
              sz_nxt = rd_q.size - rq - 17'd8;
              nx_nxt = p_r + 18'd8 + 18'(rq);
              bytes_nxt = bytes_r + rq;
              state_nxt = S_SPL;
            end else begin
              wdata = '{1'b1, rd_q.size, rd_q.prev};
              bytes_nxt = bytes_r + rd_q.size;
              state_nxt = S_OUT;
            end
            blocks_nxt = blocks_r + 14'd1;
            ow_nxt = '{16'(p_r + 18'd8), ffha_pkg::ST_OK, bytes_nxt, blocks_nxt};
          end else if (p_nxt >= REGION_END) begin
            ow_nxt = '{16'd0, ffha_pkg::ST_NOFIT, bytes_r, blocks_r};
            state_nxt = S_OUT;
          end
        end else begin
          if (p_r + 18'd8 == off18) begin
            p_nxt = p_r;
            if (rd_q.used) begin
              we = 1'b1; waddr = AW'(p_r >> 3);
              wdata = '{1'b0, rd_q.size, rd_q.prev};
              h_nxt.used = 1'b0;
              bytes_nxt = bytes_r - rd_q.size;
              blocks_nxt = blocks_r - 14'd1;
              ow_nxt = '{16'd0, ffha_pkg::ST_OK, bytes_nxt, blocks_nxt};
              nx_nxt = p_r + 18'd8 + 18'(rd_q.size);
              state_nxt = S_RRD;
            end else begin
              ow_nxt = '{16'd0, ffha_pkg::ST_BADPTR, bytes_r, blocks_r};
              state_nxt = S_OUT;
            end
          end else if (p_r + 18'd8 > off18 || p_nxt >= REGION_END) begin
            ow_nxt = '{16'd0, ffha_pkg::ST_BADPTR, bytes_r, blocks_r};
            state_nxt = S_OUT;
          end
        end
      end
      S_SPL: begin
        we = 1'b1; waddr = AW'(nx_r >> 3);
        wdata = '{1'b0, sz_r, rq};
        nx_nxt = nx_r + 18'd8 + 18'(sz_r);
        state_nxt = (nx_r + 18'd8 + 18'(sz_r) < REGION_END) ? S_POST : S_OUT;
      end
      S_POST: begin
        raddr = AW'(nx_r >> 3);
        state_nxt = S_NRD;
      end
      S_NRD: begin
        we = 1'b1; waddr = AW'(nx_r >> 3);
        wdata = '{rd_q.used, rd_q.size, sz_r};
        state_nxt = S_OUT;
      end
      S_RRD: begin
        raddr = AW'(nx_r >> 3);
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        rf_nxt = (nx_r < REGION_END) && !rd_q.used;
        if ((nx_r < REGION_END) && !rd_q.used)
          h_nxt.size = h_r.size + 17'd8 + rd_q.size;
        l_nxt = p_r - 18'd8 - 18'(h_r.prev);
        raddr = AW'((p_r - 18'd8 - 18'(h_r.prev)) >> 3);
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (p_r != 18'd0 && p_r >= 18'(h_r.prev) + 18'd8 && !rd_q.used) begin
          sz_nxt = rd_q.size + 17'd8 + h_r.size;
          we = 1'b1; waddr = AW'(l_r >> 3);
          wdata = '{rd_q.used, rd_q.size + 17'd8 + h_r.size, rd_q.prev};
          nx_nxt = l_r + 18'd8 + 18'(rd_q.size + 17'd8 + h_r.size);
          state_nxt = S_NWR;
        end else if (rf_r) begin
          sz_nxt = h_r.size;
          we = 1'b1; waddr = AW'(p_r >> 3);
          wdata = h_r;
          nx_nxt = p_r + 18'd8 + 18'(h_r.size);
          state_nxt = S_NWR;
        end else state_nxt = S_OUT;
      end
      S_NWR: begin
        state_nxt = (nx_r < REGION_END) ? S_POST : S_OUT;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: bench/testbench.sv
// testbench: first-fit heap allocator checked against a behavioral heap predictor
`timescale 1ns / 1ps
module testbench;

  localparam int HEAP = 4096;
  localparam int DEPTH = HEAP / 8;
  localparam int HEND = DEPTH * 8;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  int   errors;
  int   cycles;
  bit   calm;

  ffha_stream_if #(.W($bits(ffha_pkg::in_word_t)))  in_ch();
  ffha_stream_if #(.W($bits(ffha_pkg::out_word_t))) out_ch();

  first_fit_heap_allocator_top #(.HEAP_BYTES(HEAP)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // heap image
  int  hsize[DEPTH];
  int  hprev[DEPTH];
  bit  hused[DEPTH];
  int  byte_total;
  int  block_total;
  int  live[$];
  ffha_pkg::out_word_t pending[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void heap_reset();
    for (int i = 0; i < DEPTH; i++) begin
      hsize[i] = 0; hprev[i] = 0; hused[i] = 0;
    end
    hsize[0] = HEND - 8;
    byte_total = 0;
    block_total = 0;
  endfunction

  function automatic void coalesce(int p);
    int r, l, s, nx;
    bit rf, lf;
    r = p + 8 + hsize[p/8];
    rf = (r < HEND) && !hused[r/8];
    lf = 0;
    l = 0;
    if (p != 0 && p >= hprev[p/8] + 8) begin
      l = p - 8 - hprev[p/8];
      lf = !hused[l/8];
    end
    if (!rf && !lf) return;
    if (rf) hsize[p/8] += 8 + hsize[r/8];
    if (lf) begin
      hsize[l/8] += 8 + hsize[p/8];
      s = l;
    end else begin
      s = p;
    end
    nx = s + 8 + hsize[s/8];
    if (nx < HEND) hprev[nx/8] = hsize[s/8];
  endfunction

  function automatic ffha_pkg::out_word_t predict_heap(ffha_pkg::in_word_t w);
    ffha_pkg::out_word_t o;
    int p, req, np, post, off;
    o = '0;
    p = 0;
    if (w.func == ffha_pkg::FUNC_ALLOC) begin
      req = (int'(w.request_size) + 7) & ~7;
      o.status = ffha_pkg::ST_NOFIT;
      while (p < HEND) begin
        if (!hused[p/8] && hsize[p/8] >= req) begin
          if (hsize[p/8] >= req + 16) begin
            np = p + 8 + req;
            hsize[np/8] = hsize[p/8] - req - 8;
            hprev[np/8] = req;
            hused[np/8] = 0;
            hsize[p/8] = req;
            post = np + 8 + hsize[np/8];
            if (post < HEND) hprev[post/8] = hsize[np/8];
          end
          hused[p/8] = 1;
          byte_total += hsize[p/8];
          block_total++;
          o.result_offset = 16'(p + 8);
          o.status = ffha_pkg::ST_OK;
          live.push_back(p + 8);
          break;
        end
        p += 8 + hsize[p/8];
      end
    end else begin
      off = int'(w.payload_offset);
      o.status = ffha_pkg::ST_BADPTR;
      if (off >= 8 && off < HEND) begin
        while (p < HEND) begin
          if (p + 8 == off) begin
            if (hused[p/8]) begin
              hused[p/8] = 0;
              byte_total -= hsize[p/8];
              block_total--;
              coalesce(p);
              o.status = ffha_pkg::ST_OK;
              foreach (live[i]) if (live[i] == off) begin
                live.delete(i);
                break;
              end
            end
            break;
          end
          if (p + 8 > off) break;
          p += 8 + hsize[p/8];
        end
      end
    end
    o.bytes_in_use = 17'(byte_total);
    o.blocks_in_use = 14'(block_total);
    return o;
  endfunction

  task automatic send_word(input logic f, input int sz, input int off);
    ffha_pkg::in_word_t w;
    int gap;
    w.func = f;
    w.request_size = sz[15:0];
    w.payload_offset = off[15:0];
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending.push_back(predict_heap(w));
    @(negedge clk);
  endtask

  // result side: random stall bursts outside the calm phase
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ffha_pkg::out_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending.size() == 0) begin
        report("result with none expected");
      end else begin
        want = pending.pop_front();
        if (got.result_offset !== want.result_offset)
          report($sformatf("offset %0d want %0d", got.result_offset, want.result_offset));
        if (got.status !== want.status)
          report($sformatf("status %0d want %0d", got.status, want.status));
        if (got.bytes_in_use !== want.bytes_in_use)
          report($sformatf("bytes %0d want %0d", got.bytes_in_use, want.bytes_in_use));
        if (got.blocks_in_use !== want.blocks_in_use)
          report($sformatf("blocks %0d want %0d", got.blocks_in_use, want.blocks_in_use));
      end
    end
  end

  function automatic int pick_live();
    if (live.size() == 0) return 8;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic test_directed();
    int a;
    send_word(ffha_pkg::FUNC_ALLOC, 0, 0);
    send_word(ffha_pkg::FUNC_FREE, 0, 8);
    send_word(ffha_pkg::FUNC_FREE, 0, 8);
    send_word(ffha_pkg::FUNC_ALLOC, 65535, 16'hffff);
    send_word(ffha_pkg::FUNC_ALLOC, HEND - 8, 0);
    send_word(ffha_pkg::FUNC_ALLOC, 1, 0);
    send_word(ffha_pkg::FUNC_FREE, 0, 8);
    send_word(ffha_pkg::FUNC_ALLOC, 1, 0);
    send_word(ffha_pkg::FUNC_ALLOC, 9, 0);
    send_word(ffha_pkg::FUNC_ALLOC, 24, 0);
    send_word(ffha_pkg::FUNC_ALLOC, 0, 0);
    send_word(ffha_pkg::FUNC_FREE, 0, 0);
    send_word(ffha_pkg::FUNC_FREE, 0, 4);
    send_word(ffha_pkg::FUNC_FREE, 0, 12);
    send_word(ffha_pkg::FUNC_FREE, 0, HEND);
    send_word(ffha_pkg::FUNC_FREE, 0, 65535);
    send_word(ffha_pkg::FUNC_FREE, 0, 24);
    send_word(ffha_pkg::FUNC_FREE, 0, 8);
    send_word(ffha_pkg::FUNC_FREE, 0, 48);
    while (live.size() > 0) begin
      a = live[0];
      send_word(ffha_pkg::FUNC_FREE, 0, a);
    end
    send_word(ffha_pkg::FUNC_ALLOC, HEND - 16, 0);
    send_word(ffha_pkg::FUNC_FREE, 0, 8);
  endtask

  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_word(ffha_pkg::FUNC_ALLOC, $urandom_range(0, 200), $urandom);
      else if (r < 50)
        send_word(ffha_pkg::FUNC_ALLOC, $urandom, $urandom);
      else if (r < 90)
        send_word(ffha_pkg::FUNC_FREE, $urandom, pick_live());
      else if (r < 95)
        send_word(ffha_pkg::FUNC_FREE, $urandom, $urandom_range(0, HEND + 8));
      else
        send_word(ffha_pkg::FUNC_FREE, $urandom, $urandom);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    calm = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    heap_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(900);
    calm = 1;
    test_random(130);
    in_ch.valid <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
